// ===== rtl/audio_crossfade_ducker_unit_macros.svh =====
// assertion macros for the crossfade ducker unit
// no dependencies; taken in by the rtl files that assert
`ifndef AUDIO_CROSSFADE_DUCKER_UNIT_MACROS_SVH
`define AUDIO_CROSSFADE_DUCKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define ACD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define ACD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ACD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/acd_pkg.sv =====
// types, constants and microcode table for the crossfade ducker unit
// no dependencies
`timescale 1ns / 1ps

package acd_pkg;

  // fixed field and register widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned STEP_W     = 21;
  localparam int unsigned LEN_REG_W  = 13;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FADE_W     = 25;

  // datapath widths
  localparam int unsigned MUL_A_W   = 18;  // signed operand
  localparam int unsigned MUL_B_W   = 25;  // unsigned operand
  localparam int unsigned PROD_W    = 43;
  localparam int unsigned G_W       = 41;  // original-audio gain, q1.40
  localparam int unsigned R_W       = 33;  // repl * gain
  localparam int unsigned ACC_W     = 58;
  localparam int unsigned RND_SHIFT = 40;
  localparam int unsigned PC_W      = 4;

  localparam logic [FADE_W-1:0] FADE_ONE = 25'h100_0000;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h1_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUCK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MONO = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]    RST_GAIN = 17'd52429;
  localparam logic [GAIN_W-1:0]    RST_DUCK = 17'd0;
  localparam logic [STEP_W-1:0]    RST_STEP = 21'd1165;
  localparam logic [LEN_REG_W-1:0] RST_LEN  = 13'd4096;

  // tuser bits and request kinds
  localparam int unsigned TUSER_REQ   = 0;
  localparam int unsigned TUSER_BLOCK = 1;
  localparam logic        REQ_LOAD    = 1'b0;
  localparam logic        REQ_PROC    = 1'b1;

  // microcode step addresses
  localparam logic [PC_W-1:0] STEP_FADE    = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL_FD  = 4'd1;
  localparam logic [PC_W-1:0] STEP_LOAD_G  = 4'd2;
  localparam logic [PC_W-1:0] STEP_MUL_RG  = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOAD_R  = 4'd4;
  localparam logic [PC_W-1:0] STEP_ACC_GLO = 4'd5;
  localparam logic [PC_W-1:0] STEP_ACC_GHI = 4'd6;
  localparam logic [PC_W-1:0] STEP_ACC_RLO = 4'd7;
  localparam logic [PC_W-1:0] STEP_ACC_RHI = 4'd8;
  localparam logic [PC_W-1:0] STEP_WRITE   = 4'd9;
  localparam logic [PC_W-1:0] STEP_DONE    = 4'd10;

  typedef enum logic [2:0] {
    MA_DUCK   = 3'd0,
    MA_SAMPLE = 3'd1,
    MA_REPL   = 3'd2,
    MA_RLO    = 3'd3,
    MA_RHI    = 3'd4
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_FADE = 2'd0,
    MB_GAIN = 2'd1,
    MB_GLO  = 2'd2,
    MB_GHI  = 2'd3
  } mul_b_e;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_FADE   = 4'd1,
    OP_LOAD_G = 4'd2,
    OP_LOAD_R = 4'd3,
    OP_ACC0   = 4'd4,
    OP_ACC16  = 4'd5,
    OP_ACC24  = 4'd6,
    OP_WRITE  = 4'd7,
    OP_OUT    = 4'd8
  } dp_op_e;

  typedef enum logic [1:0] {
    SQ_NEXT = 2'd0,
    SQ_LOOP = 2'd1,
    SQ_WAIT = 2'd2
  } seq_e;

  typedef struct packed {
    mul_a_e          ma;
    mul_b_e          mb;
    dp_op_e          op;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // control store: the product register lags the operand select by one step
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{ma: MA_DUCK, mb: MB_FADE, op: OP_NONE, seq: SQ_NEXT, target: STEP_FADE};
    unique case (pc)
      STEP_FADE:    w.op = OP_FADE;
      STEP_MUL_FD:  begin
        w.ma = MA_DUCK;
        w.mb = MB_FADE;
      end
      STEP_LOAD_G:  w.op = OP_LOAD_G;
      STEP_MUL_RG:  begin
        w.ma = MA_REPL;
        w.mb = MB_GAIN;
      end
      STEP_LOAD_R:  begin
        w.op = OP_LOAD_R;
        w.ma = MA_SAMPLE;
        w.mb = MB_GLO;
      end
      STEP_ACC_GLO: begin
        w.op = OP_ACC0;
        w.ma = MA_SAMPLE;
        w.mb = MB_GHI;
      end
      STEP_ACC_GHI: begin
        w.op = OP_ACC24;
        w.ma = MA_RLO;
        w.mb = MB_FADE;
      end
      STEP_ACC_RLO: begin
        w.op = OP_ACC0;
        w.ma = MA_RHI;
        w.mb = MB_FADE;
      end
      STEP_ACC_RHI: w.op = OP_ACC16;
      STEP_WRITE:   begin
        w.op     = OP_WRITE;
        w.seq    = SQ_LOOP;
        w.target = STEP_MUL_RG;
      end
      STEP_DONE:    begin
        w.op  = OP_OUT;
        w.seq = SQ_WAIT;
      end
      default:      w.seq = SQ_WAIT;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/audio_crossfade_ducker_unit.sv =====
// crossfade ducker top level: microcoded sequencer, shared multiplier, replacement store
// depends on acd_pkg and audio_crossfade_ducker_unit_macros.svh
`timescale 1ns / 1ps

//  channel   direction  ports                         words
//  s_axis    in         tvalid tready tdata tuser     load or process request
//  m_axis    out        tvalid tready tdata           mixed stereo frame
//  cfg       in         cfg_we_i cfg_idx_i cfg_wdata_i  register write, no read-back
//
//  a load word is written into the store on acceptance
//  a process word keeps the sequencer busy, and no new word is taken, until its frame is done;
//  the work is done by the single 18x25 multiplier, used eleven times per frame
//  a stalled m_axis holds the sequencer in its last step; one finished frame can wait
//  in the output register while the next word is accepted
//  reset clears fade level and positions and sets registers to reset values; the store is not cleared

`include "audio_crossfade_ducker_unit_macros.svh"

module audio_crossfade_ducker_unit #(
  parameter int unsigned BUFFER_DEPTH = 4096,
  parameter int unsigned CHANNELS     = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [acd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // sample_left, sample_right
  input  logic [1:0]                           s_axis_tuser,  // req_type, block_music
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata   // out_left, out_right
);

  localparam int unsigned AW     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned LEN_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CMP_W  = (LEN_W > acd_pkg::LEN_REG_W) ? LEN_W : acd_pkg::LEN_REG_W;
  localparam int unsigned MEM_W  = acd_pkg::SAMPLE_W * CHANNELS;
  localparam int unsigned SW     = acd_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [acd_pkg::GAIN_W-1:0]    gain_q;
  logic [acd_pkg::GAIN_W-1:0]    duck_q;
  logic [acd_pkg::STEP_W-1:0]    step_q;
  logic [acd_pkg::LEN_REG_W-1:0] len_q;
  logic                          mono_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= acd_pkg::RST_GAIN;
      duck_q <= acd_pkg::RST_DUCK;
      step_q <= acd_pkg::RST_STEP;
      len_q  <= acd_pkg::RST_LEN;
      mono_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acd_pkg::REG_GAIN: gain_q <= cfg_wdata_i[acd_pkg::GAIN_W-1:0];
        acd_pkg::REG_DUCK: duck_q <= cfg_wdata_i[acd_pkg::GAIN_W-1:0];
        acd_pkg::REG_STEP: step_q <= cfg_wdata_i[acd_pkg::STEP_W-1:0];
        acd_pkg::REG_LEN:  len_q  <= cfg_wdata_i[acd_pkg::LEN_REG_W-1:0];
        acd_pkg::REG_MONO: mono_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // gains above unity act as unity
  logic [acd_pkg::GAIN_W-1:0] gain_c;
  logic [acd_pkg::GAIN_W-1:0] duck_c;
  assign gain_c = (gain_q > acd_pkg::GAIN_ONE) ? acd_pkg::GAIN_ONE : gain_q;
  assign duck_c = (duck_q > acd_pkg::GAIN_ONE) ? acd_pkg::GAIN_ONE : duck_q;

  // effective loop length: zero acts as one, capped at the store depth
  logic [CMP_W-1:0] len_ext;
  logic [LEN_W-1:0] eff_len;
  assign len_ext = CMP_W'(len_q);
  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > CMP_W'(BUFFER_DEPTH)) begin
      eff_len = LEN_W'(BUFFER_DEPTH);
    end else begin
      eff_len = len_ext[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic                     busy_q, busy_d;
  logic [acd_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     ch_q, ch_d;   // 0 left, 1 right
  acd_pkg::ctrl_t           cw;
  acd_pkg::dp_op_e          op;
  logic                     in_acc;
  logic                     in_proc;
  logic                     in_load;
  logic                     m_valid_q;
  logic                     out_free;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_proc       = in_acc && (s_axis_tuser[acd_pkg::TUSER_REQ] == acd_pkg::REQ_PROC);
  assign in_load       = in_acc && (s_axis_tuser[acd_pkg::TUSER_REQ] == acd_pkg::REQ_LOAD);
  assign out_free      = !m_valid_q || m_axis_tready;

  assign cw = acd_pkg::ucode(pc_q);
  assign op = busy_q ? cw.op : acd_pkg::OP_NONE;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    ch_d   = ch_q;
    if (!busy_q) begin
      if (in_proc) begin
        busy_d = 1'b1;
        pc_d   = acd_pkg::STEP_FADE;
        ch_d   = 1'b0;
      end
    end else begin
      unique case (cw.seq)
        acd_pkg::SQ_NEXT: pc_d = pc_q + 1'b1;
        acd_pkg::SQ_LOOP: begin
          // run the channel body twice
          if (!ch_q) begin
            ch_d = 1'b1;
            pc_d = cw.target;
          end else begin
            ch_d = 1'b0;
            pc_d = pc_q + 1'b1;
          end
        end
        acd_pkg::SQ_WAIT: begin
          if (out_free) begin
            busy_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= acd_pkg::STEP_FADE;
      ch_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      ch_q   <= ch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // positions, fade level and replacement store
  // ---------------------------------------------------------------------------
  logic [AW-1:0]               play_q;
  logic [AW-1:0]               load_q;
  logic [AW-1:0]               play_fix;
  logic [AW-1:0]               load_fix;
  logic [AW-1:0]               play_adv;
  logic [AW-1:0]               load_adv;
  logic [LEN_W-1:0]            play_nxt;
  logic [LEN_W-1:0]            load_nxt;
  logic [acd_pkg::FADE_W-1:0]  fade_q;
  logic [acd_pkg::FADE_W-1:0]  fade_nxt;
  logic [acd_pkg::FADE_W:0]    fade_up;
  logic                        blk_q;

  // a position left beyond a shortened loop restarts at zero
  assign play_fix = (LEN_W'(play_q) >= eff_len) ? '0 : play_q;
  assign load_fix = (LEN_W'(load_q) >= eff_len) ? '0 : load_q;
  assign play_nxt = LEN_W'(play_fix) + LEN_W'(1);
  assign load_nxt = LEN_W'(load_fix) + LEN_W'(1);
  assign play_adv = (play_nxt >= eff_len) ? '0 : play_nxt[AW-1:0];
  assign load_adv = (load_nxt >= eff_len) ? '0 : load_nxt[AW-1:0];

  // one fade step toward the target, clamped there
  assign fade_up = {1'b0, fade_q} + (acd_pkg::FADE_W + 1)'(step_q);
  always_comb begin
    if (blk_q) begin
      fade_nxt = (fade_up > {1'b0, acd_pkg::FADE_ONE}) ? acd_pkg::FADE_ONE
                                                       : fade_up[acd_pkg::FADE_W-1:0];
    end else begin
      fade_nxt = (fade_q > acd_pkg::FADE_W'(step_q)) ? fade_q - acd_pkg::FADE_W'(step_q)
                                                     : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q <= '0;
      load_q <= '0;
      fade_q <= '0;
    end else begin
      if (in_load) begin
        load_q <= load_adv;
      end
      if (op == acd_pkg::OP_FADE) begin
        play_q <= play_adv;
        fade_q <= fade_nxt;
      end
    end
  end

  logic [MEM_W-1:0] mem_q [BUFFER_DEPTH];
  logic [MEM_W-1:0] mem_rd_q;
  logic [MEM_W-1:0] mem_wdata;

  always_comb begin
    mem_wdata = MEM_W'(s_axis_tdata[SW-1:0]);
    if (CHANNELS > 1) begin
      mem_wdata[MEM_W-1 -: SW] = s_axis_tdata[2*SW-1:SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      mem_q[load_fix] <= mem_wdata;
    end
    if (op == acd_pkg::OP_FADE) begin
      mem_rd_q <= mem_q[play_fix];
    end
  end

  // ---------------------------------------------------------------------------
  // datapath: one multiplier, product register, gain and accumulator registers
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]                in_l_q, in_r_q;
  logic signed [SW-1:0]                sample_ch;
  logic signed [SW-1:0]                repl_l, repl_r, repl_ch;
  logic signed [acd_pkg::MUL_A_W-1:0]  mul_a;
  logic        [acd_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [acd_pkg::PROD_W-1:0]   prod_q;
  logic        [acd_pkg::G_W-1:0]      g_q;
  logic signed [acd_pkg::R_W-1:0]      r_q;
  logic signed [acd_pkg::ACC_W-1:0]    acc_q;
  logic signed [acd_pkg::ACC_W-1:0]    prod_ext;
  logic signed [acd_pkg::ACC_W-1:0]    rnd;
  logic signed [acd_pkg::ACC_W-acd_pkg::RND_SHIFT-1:0] rnd_q;
  logic signed [SW-1:0]                sat;
  logic signed [SW-1:0]                res_l_q, res_r_q;
  logic [2*SW-1:0]                     m_data_q;

  assign sample_ch = ch_q ? in_r_q : in_l_q;
  assign repl_l    = mem_rd_q[SW-1:0];
  assign repl_r    = mono_q ? repl_l : mem_rd_q[MEM_W-1 -: SW];
  assign repl_ch   = ch_q ? repl_r : repl_l;

  always_comb begin
    unique case (cw.ma)
      acd_pkg::MA_DUCK:   mul_a = $signed({1'b0, duck_c});
      acd_pkg::MA_SAMPLE: mul_a = acd_pkg::MUL_A_W'(sample_ch);
      acd_pkg::MA_REPL:   mul_a = acd_pkg::MUL_A_W'(repl_ch);
      acd_pkg::MA_RLO:    mul_a = $signed({2'b00, r_q[15:0]});
      acd_pkg::MA_RHI:    mul_a = acd_pkg::MUL_A_W'($signed(r_q[acd_pkg::R_W-1:16]));
      default:            mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mb)
      acd_pkg::MB_FADE: mul_b = fade_q;
      acd_pkg::MB_GAIN: mul_b = acd_pkg::MUL_B_W'(gain_c);
      acd_pkg::MB_GLO:  mul_b = acd_pkg::MUL_B_W'(g_q[23:0]);
      acd_pkg::MB_GHI:  mul_b = acd_pkg::MUL_B_W'(g_q[acd_pkg::G_W-1:24]);
      default:          mul_b = '0;
    endcase
  end

  assign prod_ext = {{(acd_pkg::ACC_W - acd_pkg::PROD_W){prod_q[acd_pkg::PROD_W-1]}}, prod_q};

  // round half up at bit 40, then clamp to 16 bits
  assign rnd   = acc_q + (acd_pkg::ACC_W'(1) <<< (acd_pkg::RND_SHIFT - 1));
  assign rnd_q = rnd[acd_pkg::ACC_W-1:acd_pkg::RND_SHIFT];
  always_comb begin
    if (rnd_q > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (rnd_q < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rnd_q[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_proc) begin
      in_l_q <= s_axis_tdata[SW-1:0];
      in_r_q <= s_axis_tdata[2*SW-1:SW];
    end
    prod_q <= acd_pkg::PROD_W'(mul_a * $signed({1'b0, mul_b}));
    case (op)
      acd_pkg::OP_LOAD_G: begin
        // (1 - f) in q1.40 plus f * duck
        g_q   <= {acd_pkg::FADE_ONE - fade_q, 16'b0} + prod_q[acd_pkg::G_W-1:0];
        acc_q <= '0;
      end
      acd_pkg::OP_LOAD_R: r_q   <= prod_q[acd_pkg::R_W-1:0];
      acd_pkg::OP_ACC0:   acc_q <= acc_q + prod_ext;
      acd_pkg::OP_ACC16:  acc_q <= acc_q + (prod_ext <<< 16);
      acd_pkg::OP_ACC24:  acc_q <= acc_q + (prod_ext <<< 24);
      acd_pkg::OP_WRITE: begin
        if (ch_q) begin
          res_r_q <= sat;
        end else begin
          res_l_q <= sat;
        end
        acc_q <= '0;
      end
      acd_pkg::OP_OUT: begin
        if (out_free) begin
          m_data_q <= {res_r_q, res_l_q};
        end
      end
      default: ;
    endcase
  end

  // block flag follows each process word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= 1'b0;
    end else if (in_proc) begin
      blk_q <= s_axis_tuser[acd_pkg::TUSER_BLOCK];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (op == acd_pkg::OP_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ACD_ASSERT_NEXT(a_proc_starts, clk_i, rst_ni, in_proc, busy_q && pc_q == acd_pkg::STEP_FADE && !ch_q, "process word did not start the sequencer")
  `ACD_ASSERT_NEXT(a_load_idle, clk_i, rst_ni, in_load, !busy_q, "load word made the sequencer busy")
  `ACD_ASSERT_IMPL(a_fade_range, clk_i, rst_ni, 1'b1, fade_q <= acd_pkg::FADE_ONE, "fade level above unity")
  `ACD_ASSERT_IMPL(a_end_at_done, clk_i, rst_ni, $fell(busy_q), $past(pc_q) == acd_pkg::STEP_DONE, "sequencer left busy outside its last step")
  `ACD_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(m_valid_q), $past(busy_q) && $past(pc_q) == acd_pkg::STEP_DONE, "result shown outside the output step")

endmodule
